[rtl/core/present_pkg.sv]
// ----------------------------------------------------------------------------
// PRESENT cipher package
// Shared types, constants and round functions for the PRESENT 64-bit cipher.
// ----------------------------------------------------------------------------
package present_pkg;

   // Round key store geometry.
   localparam int KEY_DEPTH = 32;
   localparam int KEY_IDX_W = 5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_KEY_LO  = 2'd0;
   localparam logic [1:0] CSR_KEY_HI  = 2'd1;
   localparam logic [1:0] CSR_KEY_LEN = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEYGEN,
      ST_PREP,
      ST_ROUND,
      ST_FINAL
   } state_type;

   // Working key register of the key schedule (low half holds 16 bits for 80-bit keys).
   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } key_reg_type;

   // Control outputs of the sequencer.
   typedef struct packed {
      logic busy;
      logic key_write;
      logic round_en;
      logic out_load;
   } ctrl_type;

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
      4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   localparam logic [3:0] SBOX_INV [16] = '{
      4'h5, 4'he, 4'hf, 4'h8, 4'hc, 4'h1, 4'h2, 4'hd,
      4'hb, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'ha
   };

   // Forward S-box layer over all sixteen nibbles.
   function automatic logic [63:0] sub_fwd(input logic [63:0] s);
      logic [63:0] o;
      o = '0;
      for (int n = 0; n < 16; n++) begin
         o[4*n +: 4] = SBOX_FWD[s[4*n +: 4]];
      end
      return o;
   endfunction

   // Inverse S-box layer over all sixteen nibbles.
   function automatic logic [63:0] sub_inv(input logic [63:0] s);
      logic [63:0] o;
      o = '0;
      for (int n = 0; n < 16; n++) begin
         o[4*n +: 4] = SBOX_INV[s[4*n +: 4]];
      end
      return o;
   endfunction

   // Bit permutation: bit b moves to 16*b mod 63, which is {b[1:0], b[5:2]}.
   function automatic logic [63:0] perm_fwd(input logic [63:0] s);
      logic [63:0] o;
      logic [5:0]  b;
      o = '0;
      for (int i = 0; i < 64; i++) begin
         b = 6'(i);
         o[{b[1:0], b[5:2]}] = s[i];
      end
      return o;
   endfunction

   // Inverse bit permutation.
   function automatic logic [63:0] perm_inv(input logic [63:0] s);
      logic [63:0] o;
      logic [5:0]  b;
      o = '0;
      for (int i = 0; i < 64; i++) begin
         b = 6'(i);
         o[i] = s[{b[1:0], b[5:2]}];
      end
      return o;
   endfunction

   // One encryption round with its round key.
   function automatic logic [63:0] round_enc(input logic [63:0] s, input logic [63:0] k);
      return perm_fwd(sub_fwd(s ^ k));
   endfunction

   // One decryption round with its round key.
   function automatic logic [63:0] round_dec(input logic [63:0] s, input logic [63:0] k);
      return sub_inv(perm_inv(s ^ k));
   endfunction

   // One step of the 80-bit key schedule for round counter r.
   function automatic key_reg_type key_step80(input key_reg_type k,
                                              input logic [KEY_IDX_W-1:0] r);
      key_reg_type n;
      n.hi = {k.hi[2:0], k.lo[15:0], k.hi[63:19]};
      n.lo = {48'd0, k.hi[18:3]};
      n.hi[63:60] = SBOX_FWD[n.hi[63:60]];
      n.lo[15] = n.lo[15] ^ r[0];
      n.hi[3:0] = n.hi[3:0] ^ r[4:1];
      return n;
   endfunction

   // One step of the 128-bit key schedule for round counter r.
   function automatic key_reg_type key_step128(input key_reg_type k,
                                               input logic [KEY_IDX_W-1:0] r);
      key_reg_type n;
      n.hi = {k.hi[2:0], k.lo[63:3]};
      n.lo = {k.lo[2:0], k.hi[63:3]};
      n.hi[63:60] = SBOX_FWD[n.hi[63:60]];
      n.hi[59:56] = SBOX_FWD[n.hi[59:56]];
      n.hi[2:0] = n.hi[2:0] ^ r[4:2];
      n.lo[63:62] = n.lo[63:62] ^ r[1:0];
      return n;
   endfunction

endpackage

[rtl/core/present_block_cipher_top.sv]
// An accepted item passes the prep, round and final states when the round keys are
// current; the key schedule state runs first after reset or any configuration write. The
// block takes no new item until the last one has left the final state. The single shared round
// unit runs one round per cycle from the registered round key memory.
// Reset is synchronous and active high; it clears the sequencer, the key registers and
// marks the round keys stale. The round key memory is not cleared.
// ----------------------------------------------------------------------------
// PRESENT block cipher top level
// Iterative PRESENT-64 core with 80/128-bit key schedule and a 32-entry round key memory.
// ----------------------------------------------------------------------------
module present_block_cipher_top
   import present_pkg::*;
#(
   parameter int ROUND_COUNT = 31
) (
   input  logic        clock,
   input  logic        reset,
   // Input item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [63:0] req_block_in,
   // Result item channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_block_out,
   // Configuration write port
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [KEY_IDX_W-1:0] RndLast = KEY_IDX_W'(ROUND_COUNT);
   localparam logic [KEY_IDX_W-1:0] RndPrev = KEY_IDX_W'(ROUND_COUNT - 1);

   state_type            state_ff, state_in;
   ctrl_type             ctrl;
   logic [63:0]          cfg_key_lo_ff, cfg_key_hi_ff;
   logic                 cfg_key_len_ff;
   logic                 keys_ready_ff;
   logic                 op_ff;
   logic [KEY_IDX_W-1:0] cnt_ff, cnt_in;
   key_reg_type          kreg_ff, kreg_in;
   logic [63:0]          data_ff, data_in;
   logic [63:0]          key_mem [KEY_DEPTH];
   logic [63:0]          rd_data_ff;
   logic [KEY_IDX_W-1:0] rd_addr;
   logic [KEY_IDX_W-1:0] cnt_next;
   logic                 rsp_valid_ff;
   logic [63:0]          rsp_block_out_ff;
   logic                 accept;
   logic                 out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_next = cnt_ff + KEY_IDX_W'(1);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = keys_ready_ff ? ST_PREP : ST_KEYGEN;
            end
         end
         ST_KEYGEN: begin
            if (cnt_ff == RndLast) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (cnt_ff == RndPrev) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer control outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:   ctrl.busy = 1'b0;
         ST_KEYGEN: begin
            ctrl.busy      = 1'b1;
            ctrl.key_write = 1'b1;
         end
         ST_PREP:   ctrl.busy = 1'b1;
         ST_ROUND: begin
            ctrl.busy     = 1'b1;
            ctrl.round_en = 1'b1;
         end
         ST_FINAL: begin
            ctrl.busy     = 1'b1;
            ctrl.out_load = out_free;
         end
         default:   ctrl.busy = 1'b1;
      endcase
   end

   assign req_stall = ctrl.busy;

   // Round key address: rounds walk up for encryption and down for decryption.
   always_comb begin
      logic [KEY_IDX_W-1:0] step;
      step    = ctrl.round_en ? cnt_next : cnt_ff;
      rd_addr = op_ff ? (RndLast - step) : step;
   end

   // Counter, key schedule register and cipher state.
   always_comb begin
      cnt_in  = cnt_ff;
      kreg_in = kreg_ff;
      data_in = data_ff;
      if (accept) begin
         cnt_in  = '0;
         data_in = req_block_in;
         if (cfg_key_len_ff) begin
            kreg_in.hi = cfg_key_hi_ff;
            kreg_in.lo = cfg_key_lo_ff;
         end else begin
            kreg_in.hi = {cfg_key_hi_ff[15:0], cfg_key_lo_ff[63:16]};
            kreg_in.lo = {48'd0, cfg_key_lo_ff[15:0]};
         end
      end else if (ctrl.key_write) begin
         cnt_in  = (cnt_ff == RndLast) ? '0 : cnt_next;
         kreg_in = cfg_key_len_ff ? key_step128(kreg_ff, cnt_next)
                                  : key_step80(kreg_ff, cnt_next);
      end else if (ctrl.round_en) begin
         cnt_in  = cnt_next;
         data_in = op_ff ? round_dec(data_ff, rd_data_ff) : round_enc(data_ff, rd_data_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         keys_ready_ff  <= 1'b0;
         cfg_key_lo_ff  <= '0;
         cfg_key_hi_ff  <= '0;
         cfg_key_len_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (ctrl.key_write && (cnt_ff == RndLast)) begin
            keys_ready_ff <= 1'b1;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_KEY_LO: begin
                  cfg_key_lo_ff <= csr_wdata;
                  keys_ready_ff <= 1'b0;
               end
               CSR_KEY_HI: begin
                  cfg_key_hi_ff <= csr_wdata;
                  keys_ready_ff <= 1'b0;
               end
               CSR_KEY_LEN: begin
                  cfg_key_len_ff <= csr_wdata[0];
                  keys_ready_ff  <= 1'b0;
               end
               default: ;
            endcase
         end
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kreg_ff <= kreg_in;
      data_ff <= data_in;
      if (accept) begin
         op_ff <= req_op;
      end
      if (ctrl.out_load) begin
         rsp_block_out_ff <= data_ff ^ rd_data_ff;
      end
   end

   // Round key memory: one write port for the schedule, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.key_write) begin
         key_mem[cnt_ff] <= kreg_ff.hi;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_out_ff;

endmodule

[rtl/core/present_chk.sv]
// ----------------------------------------------------------------------------
// PRESENT cipher port checker
// Watches the top level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module present_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_block_out
);

   // Reset leaves no result item pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item pending after reset");

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_out))
      else $error("stalled result item changed or dropped");

   // An accepted item makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting an item");

   // A new result item only appears while the block has been working on an item.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item without work in progress");

endmodule

bind present_block_cipher_top present_chk u_present_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_block_out (rsp_block_out)
);
